[hdl/dqr_pkg.sv]
// Shared types and constants for the deque with remove-by-ID.
`default_nettype none

package dqr_pkg;

  localparam int DEPTH = 16;
  localparam int ID_W  = 32;
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_REMOVE     = 3'd4,
    MODE_FIND       = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef struct packed {
    mode_t            mode;
    logic [ID_W-1:0]  entity_id;
  } dqr_in_t;

  typedef struct packed {
    status_t          status;
    logic [ID_W-1:0]  result_id;
    logic [CNT_W-1:0] count_after;
  } dqr_out_t;

  // Per-cycle command broadcast to every cell; each bit is already qualified
  // by an input transfer; the push and pop bits also by the full/empty checks.
  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop_front;
    logic remove;
  } dqr_cmd_t;

endpackage

`default_nettype wire

[hdl/dqr_cell.sv]
// One storage cell of the deque chain: holds one entry ID and shifts with its neighbors.
`default_nettype none

module dqr_cell
  import dqr_pkg::*;
(
  input  wire logic            clk,
  input  wire dqr_cmd_t        cmd,
  input  wire logic [ID_W-1:0] key,
  input  wire logic            occ,
  input  wire logic            left_occ,
  input  wire logic [ID_W-1:0] left_id,
  input  wire logic            left_hit,
  input  wire logic [ID_W-1:0] right_id,
  output logic      [ID_W-1:0] id_o,
  output logic                 hit_o
);

  logic [ID_W-1:0] id_r;
  logic [ID_W-1:0] id_nxt;

  // hit_o is true when this cell or any cell nearer the front matches the key.
  assign hit_o = left_hit | (occ & (id_r == key));
  assign id_o  = id_r;

  always_comb begin
    id_nxt = id_r;
    if (cmd.push_front) begin
      id_nxt = left_id;
    end else if (cmd.push_back) begin
      // The first free cell takes the new ID.
      if (!occ && left_occ) begin
        id_nxt = key;
      end
    end else if (cmd.pop_front || (cmd.remove && hit_o)) begin
      id_nxt = right_id;
    end
  end

  always_ff @(posedge clk) begin
    id_r <= id_nxt;
  end

endmodule

`default_nettype wire

[hdl/deque_with_remove_by_id_unit.sv]
// Output: the result of each input transfer appears in the output register in the cycle after the transfer.
// Throughput: one item per cycle while out_ready is high; the key compare and shift
// run across the whole cell chain at once.
// Reset: rst_n (synchronous) empties the store and clears the output valid; the stored
// IDs themselves are not cleared and are never read before they are written.
`default_nettype none

module deque_with_remove_by_id_unit
  import dqr_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire dqr_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_ready,
  output dqr_out_t     out_data
);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  dqr_out_t         out_data_r;
  dqr_out_t         out_data_nxt;

  logic             fire;
  logic             full;
  logic             empty;
  dqr_cmd_t         cmd;

  logic [DEPTH-1:0] occ;
  logic [DEPTH-1:0] hit;
  logic [ID_W-1:0]  cell_id [DEPTH];
  logic [ID_W-1:0]  back_id;
  logic             any_hit;

  // No transfer is taken while reset is held.
  assign in_ready  = rst_n && (!out_valid_r || out_ready);
  assign fire      = in_valid && in_ready;
  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);
  assign any_hit   = hit[DEPTH-1];
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    cmd            = '0;
    cmd.push_front = fire && !full && (in_data.mode == MODE_PUSH_FRONT);
    cmd.push_back  = fire && !full && (in_data.mode == MODE_PUSH_BACK);
    cmd.pop_front  = fire && !empty && (in_data.mode == MODE_POP_FRONT);
    cmd.remove     = fire && (in_data.mode == MODE_REMOVE);
  end

  // The back entry is the occupied cell whose right neighbor is free, or the last cell when it is occupied.
  always_comb begin
    back_id = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (occ[i] && ((i == DEPTH - 1) || !occ[(i + 1) % DEPTH])) begin
        back_id = back_id | cell_id[i];
      end
    end
  end

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      assign occ[g] = (CNT_W'(g) < count_r);

      if (g == 0) begin : g_front
        dqr_cell u_cell (
          .clk      (clk),
          .cmd      (cmd),
          .key      (in_data.entity_id),
          .occ      (occ[0]),
          .left_occ (1'b1),
          .left_id  (in_data.entity_id),
          .left_hit (1'b0),
          .right_id (cell_id[(g + 1) % DEPTH]),
          .id_o     (cell_id[0]),
          .hit_o    (hit[0])
        );
      end else if (g == DEPTH - 1) begin : g_back
        dqr_cell u_cell (
          .clk      (clk),
          .cmd      (cmd),
          .key      (in_data.entity_id),
          .occ      (occ[g]),
          .left_occ (occ[g-1]),
          .left_id  (cell_id[g-1]),
          .left_hit (hit[g-1]),
          .right_id ({ID_W{1'b0}}),
          .id_o     (cell_id[g]),
          .hit_o    (hit[g])
        );
      end else begin : g_mid
        dqr_cell u_cell (
          .clk      (clk),
          .cmd      (cmd),
          .key      (in_data.entity_id),
          .occ      (occ[g]),
          .left_occ (occ[g-1]),
          .left_id  (cell_id[g-1]),
          .left_hit (hit[g-1]),
          .right_id (cell_id[g+1]),
          .id_o     (cell_id[g]),
          .hit_o    (hit[g])
        );
      end
    end
  endgenerate

  always_comb begin
    count_nxt                = count_r;
    out_valid_nxt            = out_valid_r;
    out_data_nxt             = out_data_r;
    out_data_nxt.status      = ST_MISS;
    out_data_nxt.result_id   = '0;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (fire) begin
      out_valid_nxt = 1'b1;
      unique case (in_data.mode)
        MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
          if (full) begin
            out_data_nxt.status = ST_FULL;
          end else begin
            out_data_nxt.status = ST_OK;
            count_nxt           = count_r + 1'b1;
          end
        end
        MODE_POP_FRONT: begin
          if (!empty) begin
            out_data_nxt.status    = ST_OK;
            out_data_nxt.result_id = cell_id[0];
            count_nxt              = count_r - 1'b1;
          end
        end
        MODE_POP_BACK: begin
          if (!empty) begin
            out_data_nxt.status    = ST_OK;
            out_data_nxt.result_id = back_id;
            count_nxt              = count_r - 1'b1;
          end
        end
        MODE_REMOVE: begin
          if (any_hit) begin
            out_data_nxt.status    = ST_OK;
            out_data_nxt.result_id = in_data.entity_id;
            count_nxt              = count_r - 1'b1;
          end
        end
        MODE_FIND: begin
          if (any_hit) begin
            out_data_nxt.status    = ST_OK;
            out_data_nxt.result_id = in_data.entity_id;
          end
        end
        default: begin
          out_data_nxt.status = ST_MISS;
        end
      endcase
      out_data_nxt.count_after = count_nxt;
    end else begin
      out_data_nxt = out_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count exceeds depth");

  assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("accepted item produced no result");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.status != ST_OK) |-> (out_data_r.result_id == '0))
    else $error("nonzero result ID with failing status");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.count_after == count_r))
    else $error("reported count differs from held count");

  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push_front || cmd.push_back) |=> (count_r == $past(count_r) + 1'b1))
    else $error("push did not grow the store by one");

endmodule

`default_nettype wire
